// File: rtl/oed_pkg.sv
// ----------------------------------------------------------------------------
// oed_pkg
// shared types and constants of the optimal string alignment distance block
// ----------------------------------------------------------------------------
package oed_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned VAL_W_DEF   = $clog2(MAX_LEN_DEF + 1);
  localparam int unsigned DIST_MAX    = 127;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_COMPUTE       = 2'd2
  } opcode_e;

  // row token travelling along the cell chain
  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [7:0] a;
    logic [7:0] a_prev;
  } ctl_t;

endpackage

// File: rtl/osa_edit_distance.sv
// ----------------------------------------------------------------------------
// osa_edit_distance
// optimal string alignment distance between two byte strings, computed by a
// systolic row of cells, one cell per byte of the second string
// ----------------------------------------------------------------------------
//   channel  | signals                          | beat
//   in       | in_valid_i, in_ready_o           | opcode_i, symbol_i
//   out      | out_valid_o, out_ready_i         | distance_o, too_long_o
//
// a compute beat with both strings loaded streams the first string row by row
// through the cell chain
// a compute beat with an empty string answers in the next cycle
// in_ready_o is low while a pass runs or while a result waits to be taken
// reset clears lengths, overflow flag and the pending result
module osa_edit_distance
  import oed_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] symbol_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] distance_o,
  output logic       too_long_o
);

  localparam int unsigned VW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned SW = (VW > 7) ? VW : 7;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e        state_q;
  logic [VW-1:0] len1_q;
  logic [VW-1:0] len2_q;
  logic          ovf_q;
  logic          clr_q;
  logic [VW-1:0] rd_cnt_q;
  logic          iss_q;
  logic          f_first_q;
  logic          f_last_q;
  logic [VW-1:0] row_q;
  logic [7:0]    a_prev_q;
  logic          out_valid_q;
  logic [6:0]    dist_q;
  logic          too_long_q;

  opcode_e       op;
  logic          in_fire;
  logic          rd_en;
  logic          ram_we;
  logic [7:0]    rdata;
  logic          hit;
  logic [SW-1:0] res_ext;
  logic [SW-1:0] empty_ext;
  logic [6:0]    res_sat;
  logic [6:0]    empty_sat;

  ctl_t          ctl   [MAX_LEN+1];
  logic [VW-1:0] val   [MAX_LEN+1];
  logic [VW-1:0] dfw   [MAX_LEN+1];
  logic [7:0]    b_sym [MAX_LEN+1];

  assign op         = opcode_e'(opcode_i);
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ram_we     = in_fire && (op == OP_APPEND_FIRST) && (len1_q < VW'(MAX_LEN));
  assign rd_en      = (state_q == S_RUN) && (rd_cnt_q < len1_q);

  oed_ram #(
    .Width (8),
    .Depth (MAX_LEN)
  ) u_first (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len1_q[AW-1:0]),
    .wdata_i (symbol_i),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // row source feeding the left edge of the chain
  always_comb begin
    ctl[0].vld    = iss_q;
    ctl[0].first  = f_first_q;
    ctl[0].last   = f_last_q;
    ctl[0].a      = rdata;
    ctl[0].a_prev = a_prev_q;
  end
  assign val[0]   = row_q;
  assign dfw[0]   = '0;
  assign b_sym[0] = '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    oed_cell #(
      .ValW (VW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (clr_q),
      .col_i     (VW'(j)),
      .swap_en_i (j > 0),
      .b_we_i    (in_fire && (op == OP_APPEND_SECOND) && (len2_q == VW'(j))),
      .b_i       (symbol_i),
      .b_prev_i  (b_sym[j]),
      .b_o       (b_sym[j+1]),
      .ctl_i     (ctl[j]),
      .val_i     (val[j]),
      .dfw_i     (dfw[j]),
      .ctl_o     (ctl[j+1]),
      .val_o     (val[j+1]),
      .dfw_o     (dfw[j+1])
    );
  end

  assign hit       = (state_q == S_RUN) && ctl[len2_q].vld && ctl[len2_q].last;
  assign res_ext   = SW'(val[len2_q]);
  assign empty_ext = (len1_q == '0) ? SW'(len2_q) : SW'(len1_q);
  assign res_sat   = (res_ext > SW'(DIST_MAX)) ? 7'(DIST_MAX) : res_ext[6:0];
  assign empty_sat = (empty_ext > SW'(DIST_MAX)) ? 7'(DIST_MAX) : empty_ext[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len1_q      <= '0;
      len2_q      <= '0;
      ovf_q       <= 1'b0;
      clr_q       <= 1'b0;
      rd_cnt_q    <= '0;
      iss_q       <= 1'b0;
      f_first_q   <= 1'b0;
      f_last_q    <= 1'b0;
      row_q       <= '0;
      a_prev_q    <= '0;
      out_valid_q <= 1'b0;
      dist_q      <= '0;
      too_long_q  <= 1'b0;
    end else begin
      clr_q <= 1'b0;
      iss_q <= rd_en;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rd_en) begin
        f_first_q <= (rd_cnt_q == '0);
        f_last_q  <= (rd_cnt_q == len1_q - VW'(1));
        row_q     <= rd_cnt_q + VW'(1);
        rd_cnt_q  <= rd_cnt_q + VW'(1);
      end
      if (iss_q) begin
        a_prev_q <= rdata;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (op)
              OP_APPEND_FIRST: begin
                if (len1_q < VW'(MAX_LEN)) begin
                  len1_q <= len1_q + VW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OP_APPEND_SECOND: begin
                if (len2_q < VW'(MAX_LEN)) begin
                  len2_q <= len2_q + VW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OP_COMPUTE: begin
                if ((len1_q == '0) || (len2_q == '0)) begin
                  out_valid_q <= 1'b1;
                  dist_q      <= empty_sat;
                  too_long_q  <= ovf_q;
                  len1_q      <= '0;
                  len2_q      <= '0;
                  ovf_q       <= 1'b0;
                end else begin
                  state_q  <= S_RUN;
                  clr_q    <= 1'b1;
                  rd_cnt_q <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          if (hit) begin
            out_valid_q <= 1'b1;
            dist_q      <= res_sat;
            too_long_q  <= ovf_q;
            len1_q      <= '0;
            len2_q      <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign too_long_o  = too_long_q;

  // lengths never pass the string capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len1_q <= VW'(MAX_LEN)) && (len2_q <= VW'(MAX_LEN)))
    else $error("string length beyond capacity");

  // row tokens enter the chain only during a pass
  a_feed_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q |-> (state_q == S_RUN))
    else $error("row token issued outside a pass");

  // a new result comes from a finished pass or an empty-string compute
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(hit) || $past(in_fire && (op == OP_COMPUTE))))
    else $error("result without compute");

  // a dropped byte of the first string raises the overflow flag
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op == OP_APPEND_FIRST) && (len1_q == VW'(MAX_LEN))) |=> ovf_q)
    else $error("overflow not flagged");

  // a pass always starts by initializing the chain
  a_clear_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RUN) && ($past(state_q) == S_IDLE)) |-> clr_q)
    else $error("pass started without chain init");

endmodule

// File: rtl/oed_ram.sv
// ----------------------------------------------------------------------------
// oed_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module oed_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/oed_cell.sv
// ----------------------------------------------------------------------------
// oed_cell
// one column of the distance table: holds one byte of the second string and
// updates its column value once per row token passing through
// ----------------------------------------------------------------------------
module oed_cell
  import oed_pkg::*;
#(
  parameter int unsigned ValW = VAL_W_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic [ValW-1:0] col_i,
  input  logic            swap_en_i,
  input  logic            b_we_i,
  input  logic [7:0]      b_i,
  input  logic [7:0]      b_prev_i,
  output logic [7:0]      b_o,
  input  ctl_t            ctl_i,
  input  logic [ValW-1:0] val_i,
  input  logic [ValW-1:0] dfw_i,
  output ctl_t            ctl_o,
  output logic [ValW-1:0] val_o,
  output logic [ValW-1:0] dfw_o
);

  logic [7:0]      b_q;
  logic            vld_q;
  ctl_t            pay_q;
  logic [ValW-1:0] val_q;
  logic [ValW-1:0] lp_q;
  logic [ValW-1:0] t_q;
  logic [ValW-1:0] dfw_q;

  logic [ValW:0] up1;
  logic [ValW:0] left1;
  logic [ValW:0] diag1;
  logic [ValW:0] swap1;
  logic [ValW:0] m0;
  logic [ValW:0] m1;
  logic [ValW:0] best;
  logic          swap;

  always_comb begin
    up1   = {1'b0, val_q} + (ValW+1)'(1);
    left1 = {1'b0, val_i} + (ValW+1)'(1);
    diag1 = {1'b0, lp_q} + (ValW+1)'(ctl_i.a != b_q);
    swap1 = {1'b0, t_q} + (ValW+1)'(1);
    swap  = swap_en_i && !ctl_i.first && (ctl_i.a == b_prev_i) && (ctl_i.a_prev == b_q);
    m0    = (up1 < left1) ? up1 : left1;
    m1    = (m0 < diag1) ? m0 : diag1;
    best  = (swap && (swap1 < m1)) ? swap1 : m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      b_q <= b_i;
    end
    if (clear_i) begin
      val_q <= col_i + ValW'(1);
      lp_q  <= col_i;
    end else if (ctl_i.vld) begin
      val_q <= best[ValW-1:0];
      lp_q  <= val_i;
      t_q   <= dfw_i;
      dfw_q <= lp_q;
      pay_q <= ctl_i;
    end
  end

  always_comb begin
    ctl_o     = pay_q;
    ctl_o.vld = vld_q;
  end

  assign b_o   = b_q;
  assign val_o = val_q;
  assign dfw_o = dfw_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks osa_edit_distance beat by beat: a directed table with known
// distances, then random string pairs, many built as edited copies of each
// other, scored by a local table-fill model of the distance
// ----------------------------------------------------------------------------
module testbench;
  import oed_pkg::*;

  localparam int unsigned MAX_LEN      = MAX_LEN_DEF;
  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned ITEM_TARGET  = 1050;
  localparam int unsigned SETTLE       = 2 * MAX_LEN + 8;
  localparam int unsigned LIMIT_CYCLES = 500_000;
  localparam int unsigned N_DIR        = 24;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct packed {
    logic [6:0] distance;
    logic       too_long;
  } osa_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic        typed;
    osa_result_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_COMPUTE,       8'h00, 1'b1, '{7'd0, 1'b0}},
    '{OP_UNUSED,        8'hff, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_FIRST,  8'h00, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_FIRST,  8'hff, 1'b0, '{7'd0, 1'b0}},
    '{OP_COMPUTE,       8'h00, 1'b1, '{7'd2, 1'b0}},
    '{OP_APPEND_SECOND, 8'hff, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_SECOND, 8'h00, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_SECOND, 8'h55, 1'b0, '{7'd0, 1'b0}},
    '{OP_COMPUTE,       8'hff, 1'b1, '{7'd3, 1'b0}},
    '{OP_APPEND_FIRST,  8'h61, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_FIRST,  8'h62, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_SECOND, 8'h62, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_SECOND, 8'h61, 1'b0, '{7'd0, 1'b0}},
    '{OP_COMPUTE,       8'h00, 1'b1, '{7'd1, 1'b0}},
    '{OP_APPEND_FIRST,  8'h63, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_FIRST,  8'h61, 1'b0, '{7'd0, 1'b0}},
    '{OP_UNUSED,        8'h78, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_SECOND, 8'h61, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_SECOND, 8'h62, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_SECOND, 8'h63, 1'b0, '{7'd0, 1'b0}},
    '{OP_COMPUTE,       8'h00, 1'b1, '{7'd3, 1'b0}},
    '{OP_APPEND_FIRST,  8'haa, 1'b0, '{7'd0, 1'b0}},
    '{OP_APPEND_SECOND, 8'hab, 1'b0, '{7'd0, 1'b0}},
    '{OP_COMPUTE,       8'h00, 1'b0, '{7'd0, 1'b0}}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] opcode_i    = OP_APPEND_FIRST;
  logic [7:0] symbol_i    = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [6:0] distance_o;
  logic       too_long_o;

  // local copy of the loaded strings
  logic [7:0]  first_str  [MAX_LEN];
  logic [7:0]  second_str [MAX_LEN];
  int unsigned first_len  = 0;
  int unsigned second_len = 0;
  bit          overflow   = 1'b0;

  osa_result_t pending_distances [$];
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned overflow_results = 0;
  int unsigned longest_string = 0;
  int unsigned mismatches = 0;
  bit          no_idle = 1'b0;

  osa_edit_distance #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .symbol_i   (symbol_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .distance_o (distance_o),
    .too_long_o (too_long_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d distances outstanding", pending_distances.size());
    $display("FAILURE");
    $finish;
  end

  function automatic logic [6:0] osa_distance();
    int unsigned row_two [MAX_LEN + 1];
    int unsigned row_one [MAX_LEN + 1];
    int unsigned row_cur [MAX_LEN + 1];
    int unsigned best;
    int unsigned cost;
    if (first_len == 0) return 7'(second_len);
    if (second_len == 0) return 7'(first_len);
    for (int j = 0; j <= second_len; j++) begin
      row_one[j] = j;
      row_two[j] = 0;
    end
    for (int i = 1; i <= first_len; i++) begin
      row_cur[0] = i;
      for (int j = 1; j <= second_len; j++) begin
        cost = (first_str[i-1] == second_str[j-1]) ? 0 : 1;
        best = (row_one[j] < row_cur[j-1]) ? row_one[j] + 1 : row_cur[j-1] + 1;
        if (row_one[j-1] + cost < best) best = row_one[j-1] + cost;
        if (i > 1 && j > 1 && first_str[i-1] == second_str[j-2]
            && first_str[i-2] == second_str[j-1] && row_two[j-2] + 1 < best)
          best = row_two[j-2] + 1;
        row_cur[j] = best;
      end
      row_two = row_one;
      row_one = row_cur;
    end
    best = row_one[second_len];
    if (best > DIST_MAX) best = DIST_MAX;
    return 7'(best);
  endfunction

  task automatic track_beat(input logic [1:0] op, input logic [7:0] sym,
                            input logic typed, input osa_result_t want);
    osa_result_t res;
    case (op)
      OP_APPEND_FIRST: begin
        if (first_len < MAX_LEN) begin
          first_str[first_len] = sym;
          first_len++;
        end else begin
          overflow = 1'b1;
        end
      end
      OP_APPEND_SECOND: begin
        if (second_len < MAX_LEN) begin
          second_str[second_len] = sym;
          second_len++;
        end else begin
          overflow = 1'b1;
        end
      end
      OP_COMPUTE: begin
        res.distance = osa_distance();
        res.too_long = overflow;
        if (typed) res = want;
        pending_distances.push_back(res);
        if (first_len > longest_string) longest_string = first_len;
        if (second_len > longest_string) longest_string = second_len;
        first_len = 0;
        second_len = 0;
        overflow = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [1:0] op, input logic [7:0] sym,
                           input logic typed, input osa_result_t want);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    symbol_i   <= sym;
    do @(posedge clk_i); while (!in_ready_o);
    if (op != OP_UNUSED) items_accepted++;
    track_beat(op, sym, typed, want);
  endtask

  // hold the input side off until every distance has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_sym(input bit narrow);
    return narrow ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
    if (r < 6) return MAX_LEN;
    if (r < 40) return $urandom_range(0, 3);
    return $urandom_range(0, 12);
  endfunction

  // receiver
  initial begin
    int unsigned stall;
    bit          early;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      early = no_idle ? 1'b1 : 1'($urandom_range(0, 1));
      @(negedge clk_i);
      while ((!early && !out_valid_o) || stall != 0) begin
        out_ready_i <= 1'b0;
        if (early || out_valid_o) stall--;
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    osa_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat distance=%0d too_long=%0b",
                   $realtime, distance_o, too_long_o);
      end else begin
        want = pending_distances.pop_front();
        results_checked++;
        if (want.too_long) overflow_results++;
        if (distance_o !== want.distance || too_long_o !== want.too_long) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: distance %0d/%0b expected, got %0d/%0b", $realtime,
                     want.distance, want.too_long, distance_o, too_long_o);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0]  seq_a [$];
    logic [7:0]  seq_b [$];
    int unsigned len_a;
    int unsigned len_b;
    int unsigned ia;
    int unsigned ib;
    int unsigned r;
    bit          narrow;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < N_DIR; k++)
      send_beat(DIR_ROWS[k].op, DIR_ROWS[k].sym, DIR_ROWS[k].typed, DIR_ROWS[k].want);
    drain();

    while (items_accepted < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 29) == 0) drain();
      narrow = 1'($urandom_range(0, 1));
      len_a = pick_len();
      seq_a.delete();
      seq_b.delete();
      for (int k = 0; k < len_a; k++) seq_a.push_back(rand_sym(narrow));
      if ($urandom_range(0, 2) != 0) begin
        // second string as an edited copy of the first
        for (int k = 0; k < seq_a.size(); k++) begin
          r = $urandom_range(0, 99);
          if (r < 12 && k + 1 < seq_a.size()) begin
            seq_b.push_back(seq_a[k+1]);
            seq_b.push_back(seq_a[k]);
            k++;
          end else if (r < 20) begin
            seq_b.push_back(rand_sym(narrow));
          end else if (r < 25) begin
          end else if (r < 30) begin
            seq_b.push_back(rand_sym(narrow));
            seq_b.push_back(seq_a[k]);
          end else begin
            seq_b.push_back(seq_a[k]);
          end
        end
      end else begin
        len_b = pick_len();
        for (int k = 0; k < len_b; k++) seq_b.push_back(rand_sym(narrow));
      end
      ia = 0;
      ib = 0;
      while (ia < seq_a.size() || ib < seq_b.size()) begin
        if ($urandom_range(0, 19) == 0) send_beat(OP_UNUSED, rand_sym(1'b0), 1'b0, '0);
        if (ib >= seq_b.size() || (ia < seq_a.size() && $urandom_range(0, 1) == 1)) begin
          send_beat(OP_APPEND_FIRST, seq_a[ia], 1'b0, '0);
          ia++;
        end else begin
          send_beat(OP_APPEND_SECOND, seq_b[ib], 1'b0, '0);
          ib++;
        end
      end
      // now and then the compute is left out and the next pair piles on
      if ($urandom_range(0, 9) != 0) send_beat(OP_COMPUTE, rand_sym(1'b0), 1'b0, '0);
    end
    send_beat(OP_COMPUTE, 8'h00, 1'b0, '0);
    no_idle = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("%0d beats sent, %0d distances checked, %0d with lost bytes",
             items_accepted, results_checked, overflow_results);
    $display("longest string loaded: %0d bytes, mismatches: %0d",
             longest_string, mismatches);
    if (mismatches == 0 && pending_distances.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/oed_pkg.sv
rtl/oed_ram.sv
rtl/oed_cell.sv
rtl/osa_edit_distance.sv
tb/testbench.sv
